// ===== sv/slbs_pkg.sv =====
// ============================================================================
// slbs_pkg
// Shared widths, codes, reset values and request types for the status LED
// blink and blip sequencer.
// ============================================================================
`default_nettype none

package slbs_pkg;

  localparam int TIME_BITS_DEF  = 16;
  localparam int COLOR_BITS_DEF = 24;

  localparam int REQ_W        = 2;
  localparam int PORT_COLOR_W = 24;
  localparam int PORT_TIME_W  = 16;
  localparam int MODE_W       = 2;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 24;

  // request codes
  localparam logic [REQ_W-1:0] REQ_TICK   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_BLIP   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_REDRAW = 2'd2;

  // LED modes
  localparam logic [MODE_W-1:0] MODE_OFF   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ON    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_BLINK = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DISP_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_COLOR   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLINK_PERIOD = 2'd2;

  localparam logic [MODE_W-1:0]       DISP_MODE_RST    = MODE_ON;
  localparam logic [PORT_COLOR_W-1:0] BASE_COLOR_RST   = 24'h404040;
  localparam logic [PORT_TIME_W-1:0]  BLINK_PERIOD_RST = 16'd500;

  typedef struct packed {
    logic [REQ_W-1:0]        req_type;
    logic [PORT_COLOR_W-1:0] blip_color;
    logic [PORT_TIME_W-1:0]  blip_duration;
  } req_item_t;

  typedef struct packed {
    logic      fire;
    req_item_t item;
  } issue_t;

  typedef struct packed {
    logic                    wr;
    logic [PORT_COLOR_W-1:0] color;
  } result_t;

endpackage

`default_nettype wire

// ===== sv/slbs_in_stage.sv =====
// ============================================================================
// slbs_in_stage
// Input register for requests; issues the held request to the evaluator
// when the result register can take its outcome.
// ============================================================================
`default_nettype none

module slbs_in_stage (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      req_valid,
  output logic                     req_stall,
  input  wire slbs_pkg::req_item_t req_in,
  input  wire                      res_free,
  output slbs_pkg::issue_t         issue
);
  import slbs_pkg::*;

  logic      held_valid;
  req_item_t held_item;
  logic      fire;
  logic      accept;

  assign fire      = held_valid && res_free;
  assign req_stall = rst || (held_valid && !res_free);
  assign accept    = req_valid && !req_stall;

  assign issue.fire = fire;
  assign issue.item = held_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!held_valid || fire) begin
      held_valid <= req_valid;
    end
    if (accept) begin
      held_item <= req_in;
    end
  end

endmodule

`default_nettype wire

// ===== sv/slbs_eval.sv =====
// ============================================================================
// slbs_eval
// Config registers, sequencer state and the single evaluation pass that
// turns one request into an optional LED color write.
// ============================================================================
`default_nettype none

module slbs_eval #(
  parameter int TIME_BITS  = slbs_pkg::TIME_BITS_DEF,
  parameter int COLOR_BITS = slbs_pkg::COLOR_BITS_DEF
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                cfg_we,
  input  wire [slbs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire [slbs_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire slbs_pkg::issue_t              issue,
  output slbs_pkg::result_t                  result
);
  import slbs_pkg::*;

  localparam int EW = TIME_BITS + 1;
  localparam logic [EW-1:0] ELAPSED_MAX = {EW{1'b1}};

  logic [MODE_W-1:0]     disp_mode;
  logic [COLOR_BITS-1:0] base_color;
  logic [TIME_BITS-1:0]  blink_period;

  logic [EW-1:0]         elapsed_ms;
  logic                  phase_on;
  logic                  blip_active;
  logic                  redraw_pending;
  logic [COLOR_BITS-1:0] held_blip_color;
  logic [TIME_BITS-1:0]  held_blip_duration;

  logic [COLOR_BITS-1:0] base_color_next;
  logic [EW-1:0]         elapsed_ms_next;
  logic                  phase_on_next;
  logic                  blip_active_next;
  logic                  redraw_pending_next;
  logic [COLOR_BITS-1:0] held_blip_color_next;
  logic [TIME_BITS-1:0]  held_blip_duration_next;

  logic                  start;
  logic                  wrote;
  logic [COLOR_BITS-1:0] col;
  logic [TIME_BITS-1:0]  period;

  always_comb begin
    base_color_next         = base_color;
    elapsed_ms_next         = elapsed_ms;
    phase_on_next           = phase_on;
    blip_active_next        = blip_active;
    redraw_pending_next     = redraw_pending;
    held_blip_color_next    = held_blip_color;
    held_blip_duration_next = held_blip_duration;
    start  = 1'b0;
    wrote  = 1'b0;
    col    = '0;
    period = (blink_period == '0) ? TIME_BITS'(1) : blink_period;

    case (issue.item.req_type)
      REQ_TICK: begin
        if (elapsed_ms_next != ELAPSED_MAX) begin
          elapsed_ms_next = elapsed_ms_next + EW'(1);
        end
      end
      REQ_BLIP: begin
        if (!blip_active_next) begin
          held_blip_color_next    = COLOR_BITS'(issue.item.blip_color);
          held_blip_duration_next = TIME_BITS'(issue.item.blip_duration);
          start = 1'b1;
        end
      end
      REQ_REDRAW: begin
        redraw_pending_next = 1'b1;
      end
      default: begin
      end
    endcase

    if (start) begin
      elapsed_ms_next  = '0;
      blip_active_next = 1'b1;
      phase_on_next    = 1'b1;
      col   = held_blip_color_next;
      wrote = 1'b1;
    end

    if (blip_active_next) begin
      if (phase_on_next && (elapsed_ms_next > EW'(held_blip_duration_next))) begin
        col   = base_color_next;
        wrote = 1'b1;
        phase_on_next = 1'b0;
      end
      if (!phase_on_next && (elapsed_ms_next > {held_blip_duration_next, 1'b0})) begin
        blip_active_next    = 1'b0;
        redraw_pending_next = 1'b1;
      end
    end

    if (!blip_active_next) begin
      case (disp_mode)
        MODE_OFF: begin
          if (redraw_pending_next) begin
            base_color_next = '0;
            col   = '0;
            wrote = 1'b1;
          end
        end
        MODE_ON: begin
          if (redraw_pending_next) begin
            col   = base_color_next;
            wrote = 1'b1;
          end
        end
        MODE_BLINK: begin
          if (redraw_pending_next) begin
            elapsed_ms_next = '0;
            phase_on_next   = 1'b1;
            col   = base_color_next;
            wrote = 1'b1;
          end
          if (elapsed_ms_next >= EW'(period)) begin
            elapsed_ms_next = elapsed_ms_next - EW'(period);
            phase_on_next   = !phase_on_next;
            col   = phase_on_next ? base_color_next : '0;
            wrote = 1'b1;
          end
        end
        default: begin
        end
      endcase
      redraw_pending_next = 1'b0;
    end
  end

  assign result.wr    = issue.fire && wrote;
  assign result.color = PORT_COLOR_W'(col);

  always_ff @(posedge clk) begin
    if (rst) begin
      disp_mode          <= DISP_MODE_RST;
      base_color         <= COLOR_BITS'(BASE_COLOR_RST);
      blink_period       <= TIME_BITS'(BLINK_PERIOD_RST);
      elapsed_ms         <= '0;
      phase_on           <= 1'b0;
      blip_active        <= 1'b0;
      redraw_pending     <= 1'b1;
      held_blip_color    <= '0;
      held_blip_duration <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_DISP_MODE:    disp_mode    <= cfg_data[MODE_W-1:0];
          CFG_BASE_COLOR:   base_color   <= COLOR_BITS'(cfg_data[PORT_COLOR_W-1:0]);
          CFG_BLINK_PERIOD: blink_period <= TIME_BITS'(cfg_data[PORT_TIME_W-1:0]);
          default: begin
          end
        endcase
      end else if (issue.fire) begin
        base_color <= base_color_next;
      end
      if (issue.fire) begin
        elapsed_ms         <= elapsed_ms_next;
        phase_on           <= phase_on_next;
        blip_active        <= blip_active_next;
        redraw_pending     <= redraw_pending_next;
        held_blip_color    <= held_blip_color_next;
        held_blip_duration <= held_blip_duration_next;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/slbs_out_stage.sv =====
// ============================================================================
// slbs_out_stage
// Result register holding the LED color request until the sink takes it.
// ============================================================================
`default_nettype none

module slbs_out_stage (
  input  wire                                clk,
  input  wire                                rst,
  input  wire slbs_pkg::result_t             result,
  output logic                               res_free,
  output logic                               led_valid,
  input  wire                                led_stall,
  output logic [slbs_pkg::PORT_COLOR_W-1:0]  led_color
);
  import slbs_pkg::*;

  assign res_free = !led_valid || !led_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      led_valid <= 1'b0;
    end else if (result.wr) begin
      led_valid <= 1'b1;
    end else if (!led_stall) begin
      led_valid <= 1'b0;
    end
    if (result.wr) begin
      led_color <= result.color;
    end
  end

endmodule

`default_nettype wire

// ===== sv/status_led_blink_blip_sequencer.sv =====
// ============================================================================
// status_led_blink_blip_sequencer
// Drives one RGB status LED from tick, blip and redraw requests.
//
//   channel  dir  handshake             payload
//   req      in   req_valid/req_stall   req_type, blip_color, blip_duration
//   led      out  led_valid/led_stall   led_color
//   cfg      in   cfg_we                cfg_index, cfg_data
//
// One request per cycle while req_stall is low; a color write passes from the
// input register, where its request is taken, to the result register. The whole
// pass for one request is done between those two registers.
// req_stall rises only during reset or while a full result register is stalled.
// Synchronous reset restores the register defaults and forces a redraw.
// ============================================================================
`default_nettype none

module status_led_blink_blip_sequencer #(
  parameter int TIME_BITS  = slbs_pkg::TIME_BITS_DEF,
  parameter int COLOR_BITS = slbs_pkg::COLOR_BITS_DEF
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                cfg_we,
  input  wire [slbs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire [slbs_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire                                req_valid,
  output logic                               req_stall,
  input  wire [slbs_pkg::REQ_W-1:0]          req_type,
  input  wire [slbs_pkg::PORT_COLOR_W-1:0]   blip_color,
  input  wire [slbs_pkg::PORT_TIME_W-1:0]    blip_duration,
  output logic                               led_valid,
  input  wire                                led_stall,
  output logic [slbs_pkg::PORT_COLOR_W-1:0]  led_color
);
  import slbs_pkg::*;

  req_item_t req_in;
  issue_t    issue;
  result_t   result;
  logic      res_free;

  assign req_in.req_type      = req_type;
  assign req_in.blip_color    = blip_color;
  assign req_in.blip_duration = blip_duration;

  slbs_in_stage u_in (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_in    (req_in),
    .res_free  (res_free),
    .issue     (issue)
  );

  slbs_eval #(
    .TIME_BITS  (TIME_BITS),
    .COLOR_BITS (COLOR_BITS)
  ) u_eval (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .issue     (issue),
    .result    (result)
  );

  slbs_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .result    (result),
    .res_free  (res_free),
    .led_valid (led_valid),
    .led_stall (led_stall),
    .led_color (led_color)
  );

endmodule

`default_nettype wire

// ===== sv/slbs_checker.sv =====
// ============================================================================
// slbs_checker
// Port-level checks on the status LED sequencer, bound to the top level.
// ============================================================================
`default_nettype none

module slbs_checker (
  input wire                                clk,
  input wire                                rst,
  input wire                                req_valid,
  input wire                                req_stall,
  input wire                                led_valid,
  input wire                                led_stall,
  input wire [slbs_pkg::PORT_COLOR_W-1:0]   led_color
);
  import slbs_pkg::*;

  a_led_hold: assert property (@(posedge clk) disable iff (rst)
    led_valid && led_stall |=> led_valid)
    else $error("led request dropped while stalled");

  a_led_stable: assert property (@(posedge clk) disable iff (rst)
    led_valid && led_stall |=> $stable(led_color))
    else $error("led color changed while stalled");

  // a new color request comes from a request taken into the input register and then passed to the result register
  a_led_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(led_valid) |-> $past(req_valid && !req_stall, 2))
    else $error("led request without matching input request");

  // input backs up only behind a stalled full result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> led_valid && led_stall)
    else $error("input stalled without output back-pressure");

endmodule

bind status_led_blink_blip_sequencer slbs_checker u_slbs_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .led_valid (led_valid),
  .led_stall (led_stall),
  .led_color (led_color)
);

`default_nettype wire
